// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/awbd_pkg.sv =====
// Shared constants and types for the alpha-weighted 2x2 downsampler.
package awbd_pkg;

    localparam int unsigned TEXELS     = 4;
    localparam int unsigned TEXEL_W    = 32;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned WEIGHT_W   = 9;
    localparam int unsigned PROD_W     = 17;
    localparam int unsigned ACC_W      = 18;
    localparam int unsigned WSUM_W     = 11;
    localparam int unsigned ASUM_W     = 10;
    localparam int unsigned DIV_BITS   = 8;
    // Stage 0 multiplies, stage 1 sums, then one stage per quotient bit.
    localparam int unsigned NUM_STAGES = DIV_BITS + 2;

    localparam int unsigned RED_SHIFT   = 0;
    localparam int unsigned GREEN_SHIFT = 8;
    localparam int unsigned BLUE_SHIFT  = 16;
    localparam int unsigned ALPHA_SHIFT = 24;

    typedef logic [CHAN_W-1:0]                   chan_t;
    typedef logic [TEXELS-1:0][CHAN_W-1:0]       quad_byte_t;
    typedef logic [DIV_BITS-1:0][WSUM_W-1:0]     div_vec_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
    } awbd_ctl_t;

endpackage

// ===== rtl/awbd_weight.sv =====
// Weight and alpha sums, carried down the pipeline beside the color lanes.
module awbd_weight (
    input  logic                  aclk,
    input  awbd_pkg::awbd_ctl_t   ctl,
    input  awbd_pkg::quad_byte_t  alpha,
    output awbd_pkg::div_vec_t    divisor,
    output awbd_pkg::chan_t       alpha_out
);

    logic [awbd_pkg::WSUM_W-1:0] wsum_reg [0:awbd_pkg::DIV_BITS];
    logic [awbd_pkg::ASUM_W-1:0] asum_reg [0:awbd_pkg::NUM_STAGES-1];
    logic [awbd_pkg::WSUM_W-1:0] wsum_next;
    logic [awbd_pkg::ASUM_W-1:0] asum_next;

    always_comb begin
        wsum_next = '0;
        asum_next = '0;
        for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
            asum_next = asum_next + awbd_pkg::ASUM_W'(alpha[i]);
        end
        // Each weight is alpha plus one, so the four ones add to the alpha sum.
        wsum_next = awbd_pkg::WSUM_W'(asum_next) + awbd_pkg::WSUM_W'(awbd_pkg::TEXELS);
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv[0]) begin
            wsum_reg[0] <= wsum_next;
            asum_reg[0] <= asum_next;
        end
        for (int s = 1; s <= awbd_pkg::DIV_BITS; s++) begin
            if (ctl.adv[s]) begin
                wsum_reg[s] <= wsum_reg[s-1];
            end
        end
        for (int s = 1; s < awbd_pkg::NUM_STAGES; s++) begin
            if (ctl.adv[s]) begin
                asum_reg[s] <= asum_reg[s-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < awbd_pkg::DIV_BITS; k++) begin
            divisor[k] = wsum_reg[k+1];
        end
    end

    assign alpha_out = asum_reg[awbd_pkg::NUM_STAGES-1][awbd_pkg::ASUM_W-1:2];

endmodule

// ===== rtl/awbd_lane.sv =====
// One color lane: weighting multiplies, quad sum and a pipelined restoring divider.
module awbd_lane (
    input  logic                  aclk,
    input  awbd_pkg::awbd_ctl_t   ctl,
    input  awbd_pkg::quad_byte_t  chan,
    input  awbd_pkg::quad_byte_t  alpha,
    input  awbd_pkg::div_vec_t    divisor,
    output awbd_pkg::chan_t       quotient
);

    logic [awbd_pkg::WEIGHT_W-1:0] weight   [awbd_pkg::TEXELS];
    logic [awbd_pkg::PROD_W-1:0]   prod_reg [awbd_pkg::TEXELS];
    logic [awbd_pkg::ACC_W-1:0]    acc_next;
    logic [awbd_pkg::ACC_W-1:0]    rem_reg  [0:awbd_pkg::DIV_BITS-1];
    logic [awbd_pkg::CHAN_W-1:0]   quo_reg  [1:awbd_pkg::DIV_BITS];

    always_comb begin
        for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
            weight[i] = awbd_pkg::WEIGHT_W'(alpha[i]) + awbd_pkg::WEIGHT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv[0]) begin
            for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
                prod_reg[i] <= awbd_pkg::PROD_W'(chan[i]) * awbd_pkg::PROD_W'(weight[i]);
            end
        end
    end

    always_comb begin
        acc_next = '0;
        for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
            acc_next = acc_next + awbd_pkg::ACC_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv[1]) begin
            rem_reg[0] <= acc_next;
        end
    end

    // The quotient never exceeds 255, so each stage settles one bit, MSB first.
    for (genvar k = 1; k <= awbd_pkg::DIV_BITS; k++) begin : g_div
        logic [awbd_pkg::ACC_W-1:0]  shifted;
        logic                        fits;
        logic [awbd_pkg::CHAN_W-1:0] quo_prev;

        assign shifted = awbd_pkg::ACC_W'(divisor[k-1]) << (awbd_pkg::DIV_BITS - k);
        assign fits    = rem_reg[k-1] >= shifted;

        if (k == 1) begin : g_first
            assign quo_prev = '0;
        end else begin : g_rest
            assign quo_prev = quo_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (ctl.adv[k+1]) begin
                quo_reg[k] <= quo_prev
                    | (awbd_pkg::CHAN_W'(fits) << (awbd_pkg::DIV_BITS - k));
            end
        end

        if (k < awbd_pkg::DIV_BITS) begin : g_rem
            always_ff @(posedge aclk) begin
                if (ctl.adv[k+1]) begin
                    rem_reg[k] <= fits ? rem_reg[k-1] - shifted : rem_reg[k-1];
                end
            end
        end
    end

    assign quotient = quo_reg[awbd_pkg::DIV_BITS];

endmodule

// ===== rtl/alpha_weighted_box_downsample_8888.sv =====
// Top level of the alpha-weighted 2x2 box downsampler for RGBA8888 texels.
//
//  Channel  Direction  Handshake          Word
//  s_       in         s_valid/s_ready    four 32-bit texels of one quad
//  m_       out        m_valid/m_ready    one 32-bit downsampled texel
//
// One quad enters per cycle while s_ready is high. The multiply stage loads at the
// accepting edge; the sum stage, the eight-stage divider in each color lane and
// the output register follow it.
// Reset clears only the valid bits; data registers hold whatever they last took.
// A stalled output holds its word; earlier stages keep filling until every
// stage holds a word, and only then does s_ready fall.
module alpha_weighted_box_downsample_8888 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_texel_top_left,
    input  logic [31:0] s_texel_top_right,
    input  logic [31:0] s_texel_bottom_left,
    input  logic [31:0] s_texel_bottom_right,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_texel_out
);

    logic [awbd_pkg::TEXEL_W-1:0]    texel [awbd_pkg::TEXELS];
    awbd_pkg::quad_byte_t            red_q, green_q, blue_q, alpha_q;
    awbd_pkg::awbd_ctl_t             ctl;
    awbd_pkg::div_vec_t              divisor;
    awbd_pkg::chan_t                 red_out, green_out, blue_out, alpha_out;
    logic [awbd_pkg::NUM_STAGES-1:0] valid_reg;
    logic                            out_adv;
    logic                            m_valid_reg;
    logic [awbd_pkg::TEXEL_W-1:0]    texel_out_reg;

    assign texel[0] = s_texel_top_left;
    assign texel[1] = s_texel_top_right;
    assign texel[2] = s_texel_bottom_left;
    assign texel[3] = s_texel_bottom_right;

    always_comb begin
        for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
            red_q[i]   = texel[i][awbd_pkg::RED_SHIFT   +: awbd_pkg::CHAN_W];
            green_q[i] = texel[i][awbd_pkg::GREEN_SHIFT +: awbd_pkg::CHAN_W];
            blue_q[i]  = texel[i][awbd_pkg::BLUE_SHIFT  +: awbd_pkg::CHAN_W];
            alpha_q[i] = texel[i][awbd_pkg::ALPHA_SHIFT +: awbd_pkg::CHAN_W];
        end
    end

    // A stage may load when it is empty or when the stage after it moves on,
    // so bubbles close up behind a stalled output.
    assign out_adv = !m_valid_reg || m_ready;

    always_comb begin
        ctl.adv[awbd_pkg::NUM_STAGES-1] = !valid_reg[awbd_pkg::NUM_STAGES-1] || out_adv;
        for (int s = awbd_pkg::NUM_STAGES - 2; s >= 0; s--) begin
            ctl.adv[s] = !valid_reg[s] || ctl.adv[s+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctl.adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int s = 1; s < awbd_pkg::NUM_STAGES; s++) begin
                if (ctl.adv[s]) begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
            if (out_adv) begin
                m_valid_reg <= valid_reg[awbd_pkg::NUM_STAGES-1];
            end
        end
    end

    awbd_weight u_weight (
        .aclk      (aclk),
        .ctl       (ctl),
        .alpha     (alpha_q),
        .divisor   (divisor),
        .alpha_out (alpha_out)
    );

    awbd_lane u_lane_red (
        .aclk     (aclk),
        .ctl      (ctl),
        .chan     (red_q),
        .alpha    (alpha_q),
        .divisor  (divisor),
        .quotient (red_out)
    );

    awbd_lane u_lane_green (
        .aclk     (aclk),
        .ctl      (ctl),
        .chan     (green_q),
        .alpha    (alpha_q),
        .divisor  (divisor),
        .quotient (green_out)
    );

    awbd_lane u_lane_blue (
        .aclk     (aclk),
        .ctl      (ctl),
        .chan     (blue_q),
        .alpha    (alpha_q),
        .divisor  (divisor),
        .quotient (blue_out)
    );

    // Merge stage: the three lane quotients and the alpha average form one texel.
    always_ff @(posedge aclk) begin
        if (out_adv) begin
            texel_out_reg <= {alpha_out, blue_out, green_out, red_out};
        end
    end

    assign s_ready     = ctl.adv[0];
    assign m_valid     = m_valid_reg;
    assign m_texel_out = texel_out_reg;

endmodule

// ===== rtl/awbd_checker.sv =====
// Port-level checker for the downsampler, bound to its top level.
`include "assert_macros.svh"

module awbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_texel_out
);

    // A word that waits on the output keeps its value.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_texel_out))

    // Nothing is offered on the output right after reset.
    `ASSERT_IMPLY(a_reset_empty, aclk, aresetn, $past(!aresetn), !m_valid)

    // When the output can move, the whole pipeline moves, so input is taken.
    `ASSERT_IMPLY(a_ready_when_free, aclk, aresetn, !m_valid || m_ready, s_ready)

    // A refused input means every stage is full, so a word must be waiting.
    `ASSERT_IMPLY(a_stall_has_word, aclk, aresetn, s_valid && !s_ready, m_valid && !m_ready)

endmodule

bind alpha_weighted_box_downsample_8888 awbd_checker u_awbd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_texel_out (m_texel_out)
);

// ===== tb/alpha_weighted_box_downsample_8888_tb.sv =====
// Self-checking testbench for the alpha-weighted 2x2 RGBA8888 box downsampler.
`timescale 1ns / 100ps

module alpha_weighted_box_downsample_8888_tb;

    localparam int unsigned RANDOM_QUADS   = 650;
    localparam int unsigned SINK_HOLD      = 60;
    localparam int unsigned DRAIN_CYCLES   = 24;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned IDLE_PERCENT   = 11;

    typedef logic [awbd_pkg::TEXEL_W-1:0] texel_t;
    typedef logic [awbd_pkg::CHAN_W-1:0]  byte_t;

    // Holds the downsampled texels still owed by the block, oldest first.
    class downsample_scoreboard;
        texel_t expected_texels[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // Alpha-weighted mean of each color lane; alpha is a plain average.
        function texel_t blend_quad(input texel_t quad [awbd_pkg::TEXELS]);
            logic [awbd_pkg::WEIGHT_W-1:0] weight;
            logic [awbd_pkg::ACC_W-1:0]    red_sum, green_sum, blue_sum;
            logic [awbd_pkg::WSUM_W-1:0]   weight_sum;
            logic [awbd_pkg::ASUM_W-1:0]   alpha_sum;
            logic [awbd_pkg::ACC_W-1:0]    red_mean, green_mean, blue_mean;
            byte_t                         alpha, red, green, blue;
            texel_t                        texel;
            red_sum = '0;
            green_sum = '0;
            blue_sum = '0;
            weight_sum = '0;
            alpha_sum = '0;
            for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
                alpha = quad[i][awbd_pkg::ALPHA_SHIFT +: awbd_pkg::CHAN_W];
                red   = quad[i][awbd_pkg::RED_SHIFT +: awbd_pkg::CHAN_W];
                green = quad[i][awbd_pkg::GREEN_SHIFT +: awbd_pkg::CHAN_W];
                blue  = quad[i][awbd_pkg::BLUE_SHIFT +: awbd_pkg::CHAN_W];
                weight = awbd_pkg::WEIGHT_W'(alpha) + awbd_pkg::WEIGHT_W'(1);
                red_sum = red_sum
                    + awbd_pkg::ACC_W'(red) * awbd_pkg::ACC_W'(weight);
                green_sum = green_sum
                    + awbd_pkg::ACC_W'(green) * awbd_pkg::ACC_W'(weight);
                blue_sum = blue_sum
                    + awbd_pkg::ACC_W'(blue) * awbd_pkg::ACC_W'(weight);
                weight_sum = weight_sum + awbd_pkg::WSUM_W'(weight);
                alpha_sum = alpha_sum + awbd_pkg::ASUM_W'(alpha);
            end
            red_mean = red_sum / awbd_pkg::ACC_W'(weight_sum);
            green_mean = green_sum / awbd_pkg::ACC_W'(weight_sum);
            blue_mean = blue_sum / awbd_pkg::ACC_W'(weight_sum);
            texel = '0;
            texel[awbd_pkg::RED_SHIFT +: awbd_pkg::CHAN_W] = red_mean[awbd_pkg::CHAN_W-1:0];
            texel[awbd_pkg::GREEN_SHIFT +: awbd_pkg::CHAN_W] =
                green_mean[awbd_pkg::CHAN_W-1:0];
            texel[awbd_pkg::BLUE_SHIFT +: awbd_pkg::CHAN_W] = blue_mean[awbd_pkg::CHAN_W-1:0];
            texel[awbd_pkg::ALPHA_SHIFT +: awbd_pkg::CHAN_W] = alpha_sum[awbd_pkg::ASUM_W-1:2];
            return texel;
        endfunction

        function void note_quad(texel_t tl, texel_t tr, texel_t bl, texel_t br);
            texel_t quad [awbd_pkg::TEXELS];
            quad = '{tl, tr, bl, br};
            expected_texels.push_back(blend_quad(quad));
        endfunction

        function void check_texel(texel_t got);
            texel_t want;
            if (expected_texels.size() == 0) begin
                $display("%0t: unexpected output word, expected none, actual %08h", $time, got);
                errors++;
                return;
            end
            want = expected_texels.pop_front();
            if (got !== want) begin
                $display("%0t: texel_out mismatch, expected %08h, actual %08h",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_texels.size();
        endfunction
    endclass

    logic   aclk = 1'b0;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    texel_t s_texel_top_left;
    texel_t s_texel_top_right;
    texel_t s_texel_bottom_left;
    texel_t s_texel_bottom_right;
    logic   m_valid;
    logic   m_ready;
    texel_t m_texel_out;

    logic   idle_gaps;
    logic   sink_hold_req;
    int unsigned cycle_count;

    downsample_scoreboard sb;

    alpha_weighted_box_downsample_8888 dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_texel_top_left     (s_texel_top_left),
        .s_texel_top_right    (s_texel_top_right),
        .s_texel_bottom_left  (s_texel_bottom_left),
        .s_texel_bottom_right (s_texel_bottom_right),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_texel_out          (m_texel_out)
    );

    always #1 aclk = ~aclk;

    // Both handshakes are sampled here, before any of this step's updates land.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_quad(s_texel_top_left, s_texel_top_right,
                         s_texel_bottom_left, s_texel_bottom_right);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_texel(m_texel_out);
        end
    end

    initial begin : result_sink
        int unsigned hold_left;
        bit          hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = SINK_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (idle_gaps && $urandom_range(99) < IDLE_PERCENT) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("alpha_weighted_box_downsample_8888_tb: done, errors");
        $finish;
    end

    // Offers one quad and returns at the edge where it is taken.
    task automatic send_quad(input texel_t tl, input texel_t tr,
                             input texel_t bl, input texel_t br);
        while (idle_gaps && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_texel_top_left <= tl;
        s_texel_top_right <= tr;
        s_texel_bottom_left <= bl;
        s_texel_bottom_right <= br;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic texel_t random_texel(input int unsigned flavor,
                                            input byte_t shared_alpha);
        texel_t texel;
        texel = $urandom();
        unique case (flavor)
            1: texel[awbd_pkg::ALPHA_SHIFT +: awbd_pkg::CHAN_W] =
                   $urandom_range(1) ? 8'hFF : 8'h00;
            2: texel[awbd_pkg::ALPHA_SHIFT +: awbd_pkg::CHAN_W] = shared_alpha;
            3: begin
                for (int c = 0; c < 3; c++) begin
                    texel[c*awbd_pkg::CHAN_W +: awbd_pkg::CHAN_W] =
                        $urandom_range(1) ? 8'hFF : 8'h00;
                end
            end
            default: ;
        endcase
        return texel;
    endfunction

    initial begin : stimulus
        texel_t              quad [awbd_pkg::TEXELS];
        int unsigned         flavor;
        byte_t               shared_alpha;
        sb = new();
        aresetn <= 1'b0;
        idle_gaps <= 1'b1;
        sink_hold_req <= 1'b0;
        s_valid <= 1'b0;
        s_texel_top_left <= '0;
        s_texel_top_right <= '0;
        s_texel_bottom_left <= '0;
        s_texel_bottom_right <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes, then the smallest and largest weight sums.
        send_quad(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_quad(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_quad(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
        send_quad(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000);
        send_quad(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_quad(32'hFF00_0000, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
        send_quad(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_quad(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_quad(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'hF0E1_D2C3);
        // Alpha sum that is not a multiple of four, so the shift truncates.
        send_quad(32'h0180_40C0, 32'h01FF_0010, 32'h0100_FF33, 32'h0077_8899);
        send_quad(32'hFF12_3456, 32'hFF65_4321, 32'hFFAB_CDEF, 32'hFFFE_DCBA);
        // One opaque texel in each corner, the rest fully transparent.
        for (int p = 0; p < awbd_pkg::TEXELS; p++) begin
            for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
                quad[i] = {8'h00, 24'($urandom())};
            end
            quad[p] = {8'hFF, 24'($urandom())};
            send_quad(quad[0], quad[1], quad[2], quad[3]);
        end
        s_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_QUADS; n++) begin
            if (n == 150) idle_gaps <= 1'b0;
            if (n == 250) sink_hold_req <= 1'b1;
            if (n == 350) idle_gaps <= 1'b1;
            if (n == 450) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            flavor = $urandom_range(3);
            shared_alpha = awbd_pkg::CHAN_W'($urandom());
            for (int i = 0; i < awbd_pkg::TEXELS; i++) begin
                quad[i] = random_texel(flavor, shared_alpha);
            end
            send_quad(quad[0], quad[1], quad[2], quad[3]);
        end
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("alpha_weighted_box_downsample_8888_tb: done, clean");
        end else begin
            $display("alpha_weighted_box_downsample_8888_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/awbd_pkg.sv
rtl/awbd_weight.sv
rtl/awbd_lane.sv
rtl/alpha_weighted_box_downsample_8888.sv
rtl/awbd_checker.sv
tb/alpha_weighted_box_downsample_8888_tb.sv
